>>> sv/aes_pkg.sv
// aes_pkg: constants, s-box tables and gf(2^8) helpers for the aes-128 engine
// no dependencies
package aes_pkg;

	localparam int DefRounds = 10;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_ENC  = 2'd1;
	localparam logic [1:0] ACT_DEC  = 2'd2;

	typedef logic [7:0] byte_t;

	localparam byte_t SBOX_FWD [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// multiply by x modulo the field polynomial 0x11b
	function automatic byte_t xt(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t mul2(input byte_t a);
		return xt(a);
	endfunction

	function automatic byte_t mul3(input byte_t a);
		return xt(a) ^ a;
	endfunction

	function automatic byte_t mul9(input byte_t a);
		return xt(xt(xt(a))) ^ a;
	endfunction

	function automatic byte_t mul11(input byte_t a);
		return xt(xt(xt(a))) ^ xt(a) ^ a;
	endfunction

	function automatic byte_t mul13(input byte_t a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
	endfunction

	function automatic byte_t mul14(input byte_t a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
	endfunction

endpackage

>>> sv/aes128_block_cipher.sv
// aes128_block_cipher: byte-serial aes cipher and inverse cipher with a loaded round-key table
// depends on aes_pkg
//
// Each encrypt or decrypt block runs NUM_ROUNDS+1 passes from transfer in to result: each
// round is one byte-serial pass through a single byte lane, one result byte per cycle, with
// the round-key word registered from the key table ahead of its use. Load items write one
// key word when key_index lies inside the table. The input stalls while a block is being
// worked on; a finished result waits in the output register, so the next item is taken while
// it is still held. Key words must be loaded before a block reads them.
module aes128_block_cipher #(
	parameter int NUM_ROUNDS = aes_pkg::DefRounds
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [5:0]  key_index,
	input  logic [31:0] key_word,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic        was_decrypt
);
	import aes_pkg::*;

	localparam int KeyWords = 4 * (NUM_ROUNDS + 1);
	localparam int KAW      = $clog2(KeyWords);
	localparam int PW       = $clog2(NUM_ROUNDS + 1);

	logic [31:0]   key_mem [KeyWords];
	logic [31:0]   key_rd_q;
	logic [KAW-1:0] rd_addr;
	logic [PW-1:0] kround;

	byte_t         cur_q [16];
	byte_t         nx_q [16];
	logic          busy_q, fin_q, dec_q;
	logic [PW-1:0] pass_q;
	logic [4:0]    cnt_q;
	logic          rsp_valid_q;
	logic [63:0]   out_high_q, out_low_q;
	logic          was_dec_q;

	logic   acc_in, do_load;
	byte_t  res;

	assign req_stall = busy_q;
	assign acc_in    = req_valid && !busy_q;
	assign do_load   = acc_in && action == ACT_LOAD && key_index < 6'(KeyWords);

	assign kround  = dec_q ? PW'(NUM_ROUNDS) - pass_q : pass_q;
	assign rd_addr = KAW'({kround, cnt_q[3:2]});

	always_ff @(posedge clk) begin
		if (do_load)
			key_mem[KAW'(key_index)] <= key_word;
		key_rd_q <= key_mem[rd_addr];
	end

	// one result byte of the current pass
	always_comb begin
		logic [3:0] bi;
		logic [1:0] rw, cl, src_c, ix;
		byte_t      u [4];
		byte_t      w [4];
		byte_t      kb [4];
		byte_t      sb;
		bi = 4'(cnt_q - 5'd1);
		rw = bi[1:0];
		cl = bi[3:2];
		ix = 2'(rw + 2'd2);
		for (int k = 0; k < 4; k++) begin
			kb[k] = key_rd_q[31-8*k -: 8];
			src_c = dec_q ? cl - 2'(k) : cl + 2'(k);
			sb    = cur_q[{src_c, 2'(k)}];
			u[k]  = dec_q ? SBOX_INV[sb] : SBOX_FWD[sb];
			w[k]  = u[k] ^ kb[k];
		end
		if (pass_q == '0) begin
			res = cur_q[bi] ^ kb[rw];
		end else if (pass_q == PW'(NUM_ROUNDS)) begin
			res = w[rw];
		end else if (dec_q) begin
			res = mul14(w[rw]) ^ mul11(w[2'(rw + 2'd1)]) ^ mul13(w[ix])
				^ mul9(w[2'(rw + 2'd3)]);
		end else begin
			res = mul2(u[rw]) ^ mul3(u[2'(rw + 2'd1)]) ^ u[ix] ^ u[2'(rw + 2'd3)] ^ kb[rw];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && (action == ACT_ENC || action == ACT_DEC)) begin
			for (int b = 0; b < 8; b++) begin
				cur_q[b]     <= block_high[63-8*b -: 8];
				cur_q[8 + b] <= block_low[63-8*b -: 8];
			end
		end else if (busy_q && !fin_q && cnt_q != 5'd0) begin
			nx_q[4'(cnt_q - 5'd1)] <= res;
			if (cnt_q == 5'd16) begin
				for (int b = 0; b < 15; b++)
					cur_q[b] <= nx_q[b];
				cur_q[15] <= res;
			end
		end
		if (fin_q && !(rsp_valid_q && rsp_stall)) begin
			for (int b = 0; b < 8; b++) begin
				out_high_q[63-8*b -: 8] <= cur_q[b];
				out_low_q[63-8*b -: 8]  <= cur_q[8 + b];
			end
			was_dec_q <= dec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_q       <= 1'b0;
			dec_q       <= 1'b0;
			pass_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			if (acc_in && (action == ACT_ENC || action == ACT_DEC)) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				dec_q  <= action == ACT_DEC;
				pass_q <= '0;
				cnt_q  <= '0;
			end else if (busy_q && !fin_q) begin
				if (cnt_q == 5'd16) begin
					cnt_q <= '0;
					if (pass_q == PW'(NUM_ROUNDS))
						fin_q <= 1'b1;
					else
						pass_q <= pass_q + PW'(1);
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end else if (fin_q && !(rsp_valid_q && rsp_stall)) begin
				// result moves into the output register
				rsp_valid_q <= 1'b1;
				fin_q       <= 1'b0;
				busy_q      <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign out_high    = out_high_q;
	assign out_low     = out_low_q;
	assign was_decrypt = was_dec_q;

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for aes128_block_cipher, cipher and inverse cipher on random blocks
// depends on aes_pkg and aes128_block_cipher; the class below predicts each result block
`timescale 1ns / 1ps

module tb_top;
	import aes_pkg::*;

	localparam int KeyWords = 4 * (DefRounds + 1);
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        dec;
	} cipher_result_t;

	class cipher_scoreboard;
		logic [31:0]    key_table [KeyWords];
		byte_t          st [16];
		cipher_result_t pending [$];
		int             mismatches;

		function new();
			foreach (key_table[i]) key_table[i] = '0;
			mismatches = 0;
		endfunction

		function byte_t gmul(byte_t a, byte_t b);
			byte_t acc;
			acc = '0;
			for (int i = 0; i < 8; i++) begin
				if (b[i]) acc ^= a;
				a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			end
			return acc;
		endfunction

		function void add_round_key(int r);
			logic [31:0] w;
			for (int c = 0; c < 4; c++) begin
				w = key_table[4 * r + c];
				for (int k = 0; k < 4; k++) st[4 * c + k] ^= w[31 - 8 * k -: 8];
			end
		endfunction

		function void sub_all(bit inv);
			for (int i = 0; i < 16; i++) st[i] = inv ? SBOX_INV[st[i]] : SBOX_FWD[st[i]];
		endfunction

		function void rotate_rows(bit inv);
			byte_t t [16];
			t = st;
			for (int r = 1; r < 4; r++)
				for (int c = 0; c < 4; c++) begin
					if (inv) st[r + 4 * ((c + r) & 3)] = t[r + 4 * c];
					else st[r + 4 * c] = t[r + 4 * ((c + r) & 3)];
				end
		endfunction

		function void mix_all(bit inv);
			byte_t coef [4];
			byte_t t [4];
			if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
			else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					t[r] = '0;
					for (int k = 0; k < 4; k++) t[r] ^= gmul(coef[(k - r + 4) & 3], st[4 * c + k]);
				end
				for (int r = 0; r < 4; r++) st[4 * c + r] = t[r];
			end
		endfunction

		// one accepted input transfer: key writes update the table, blocks queue a result
		function void note_input(logic [1:0] act, logic [5:0] idx, logic [31:0] word,
			logic [63:0] bh, logic [63:0] bl);
			cipher_result_t res;
			if (act == ACT_LOAD) begin
				if (idx < KeyWords) key_table[idx] = word;
				return;
			end
			if (act != ACT_ENC && act != ACT_DEC) return;
			for (int i = 0; i < 8; i++) begin
				st[i] = bh[63 - 8 * i -: 8];
				st[8 + i] = bl[63 - 8 * i -: 8];
			end
			if (act == ACT_ENC) begin
				add_round_key(0);
				for (int r = 1; r < DefRounds; r++) begin
					sub_all(0);
					rotate_rows(0);
					mix_all(0);
					add_round_key(r);
				end
				sub_all(0);
				rotate_rows(0);
				add_round_key(DefRounds);
			end else begin
				add_round_key(DefRounds);
				for (int r = DefRounds - 1; r > 0; r--) begin
					rotate_rows(1);
					sub_all(1);
					add_round_key(r);
					mix_all(1);
				end
				rotate_rows(1);
				sub_all(1);
				add_round_key(0);
			end
			for (int i = 0; i < 8; i++) begin
				res.hi[63 - 8 * i -: 8] = st[i];
				res.lo[63 - 8 * i -: 8] = st[8 + i];
			end
			res.dec = (act == ACT_DEC);
			pending.push_back(res);
		endfunction

		function void check_result(logic [63:0] hi, logic [63:0] lo, logic dec);
			cipher_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h dec=%b", hi, lo, dec);
				return;
			end
			want = pending.pop_front();
			if (hi !== want.hi || lo !== want.lo || dec !== want.dec) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %h %h dec=%b, got %h %h dec=%b",
						want.hi, want.lo, want.dec, hi, lo, dec);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_stall;
	logic [1:0]  action = ACT_LOAD;
	logic [5:0]  key_index = '0;
	logic [31:0] key_word = '0;
	logic [63:0] block_high = '0;
	logic [63:0] block_low = '0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	logic [63:0] out_high;
	logic [63:0] out_low;
	logic        was_decrypt;

	cipher_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	aes128_block_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.action(action), .key_index(key_index), .key_word(key_word),
		.block_high(block_high), .block_low(block_low),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.out_high(out_high), .out_low(out_low), .was_decrypt(was_decrypt)
	);

	always #1 clk = ~clk;

	// receiver: random stall, or a long hold-off so the engine backs up
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall = 1;
			hold_cycles--;
		end else
			rsp_stall = ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_result(out_high, out_low, was_decrypt);
	end

	task automatic send(logic [1:0] act, logic [5:0] idx, logic [31:0] word,
		logic [63:0] bh, logic [63:0] bl);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 0;
			@(negedge clk);
		end
		action = act;
		key_index = idx;
		key_word = word;
		block_high = bh;
		block_low = bl;
		req_valid = 1;
		do @(posedge clk); while (req_stall);
		sb.note_input(act, idx, word, bh, bl);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_block(logic [1:0] act, logic [63:0] bh, logic [63:0] bl);
		send(act, 6'($urandom), $urandom, bh, bl);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		int pick;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				send_block($urandom_range(1) ? ACT_ENC : ACT_DEC, rand64(), rand64());
			else if (pick < 92)
				send(ACT_LOAD, 6'($urandom_range(KeyWords - 1)), $urandom, rand64(), rand64());
			else if (pick < 96)
				send(ACT_LOAD, 6'($urandom_range(63, KeyWords)), $urandom, rand64(), rand64());
			else
				send(ACT_NONE, 6'($urandom), $urandom, rand64(), rand64());
		end
	endtask

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// fill the whole key table before any block reads it
		for (int i = 0; i < KeyWords; i++) send(ACT_LOAD, 6'(i), $urandom, '0, '1);
		send(ACT_LOAD, 6'd0, 32'h0, '0, '0);
		send(ACT_LOAD, 6'(KeyWords - 1), 32'hffff_ffff, '0, '0);
		send(ACT_LOAD, 6'(KeyWords), 32'hffff_ffff, '1, '1);
		send(ACT_LOAD, 6'd63, 32'h1234_5678, '1, '1);
		send_block(ACT_ENC, '0, '0);
		send_block(ACT_ENC, '1, '1);
		send_block(ACT_DEC, '0, '0);
		send_block(ACT_DEC, '1, '1);
		send(ACT_NONE, '1, '1, '1, '1);
		send_block(ACT_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		send_block(ACT_DEC, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0080);

		random_phase(400, 0, 0);
		random_phase(430, 54, 0);
		random_phase(430, 0, 54);
		// backpressure: hold the output off while items keep coming
		hold_cycles = 800;
		random_phase(450, 26, 26);

		@(negedge clk);
		req_valid = 0;
		waited = 0;
		while (sb.pending.size() != 0 && waited < 100_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (400) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
sv/aes_pkg.sv
sv/aes128_block_cipher.sv
test/tb_top.sv
